// File: sv/sha1_pkg.sv
package sha1_pkg;

	localparam int QueueDepth = 4;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// request between front end and back end
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (r < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (r < 7'd40) begin
			f = b ^ c ^ d;
		end else if (r < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] r);
		logic [31:0] k;
		if (r < 7'd20) begin
			k = K0;
		end else if (r < 7'd40) begin
			k = K1;
		end else if (r < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

endpackage

// File: sv/sha1_front.sv
module sha1_front #(
	parameter int Depth = sha1_pkg::QueueDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sha1_pkg::req_t  in_req,
	output logic            q_valid,
	input  logic            q_ready,
	output sha1_pkg::req_t  q_req
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	sha1_pkg::req_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != (AW+1)'(Depth));
	assign q_valid  = (cnt_q != '0);
	assign q_req    = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// File: sv/sha1_core.sv
module sha1_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  sha1_pkg::req_t  q_req,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     digest_word,
	output logic [2:0]      word_index,
	output logic            last_word
);

	sha1_pkg::state_t state_q, state_d;

	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];          // 16-word schedule window, shifts each round
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [6:0]  rnd_q;
	logic        fin_q;             // end mark pending after this compression
	logic        lenblk_q;          // current pad block holds the length
	logic [2:0]  idx_q;
	logic        pad_done_q;        // 0x80 byte already in the block buffer

	logic [31:0] wnext, wcur, t;
	logic        take;
	logic [7:0]  pbyte;
	logic [5:0]  pad_pos;           // where the 0x80 byte lands on an end mark

	assign wcur  = w_q[0];
	assign wnext = {w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]} << 1
		| {31'd0, (w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31])};
	assign t = {a_q[26:0], a_q[31:27]} + sha1_pkg::round_f(rnd_q, b_q, c_q, d_q) + e_q
		+ sha1_pkg::round_k(rnd_q) + wcur;

	assign q_ready = (state_q == sha1_pkg::ST_IDLE);
	assign take    = q_valid && q_ready;
	assign pad_pos = fill_q + 6'(q_req.byte_present);

	assign out_valid   = (state_q == sha1_pkg::ST_EMIT);
	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd4);

	// byte written by the pad sequencer at fill_q
	always_comb begin
		if (fill_q >= 6'd56 && lenblk_q) begin
			pbyte = len_q[8'(63 - {fill_q[2:0], 3'd0}) -: 8];
		end else begin
			pbyte = 8'h00;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sha1_pkg::ST_IDLE: begin
				if (take) begin
					if (q_req.byte_present && fill_q == 6'd63) begin
						state_d = sha1_pkg::ST_ROUND;
					end else if (q_req.end_of_message) begin
						// pad byte in the last slot leaves nothing to fill
						if (pad_pos == 6'd63) begin
							state_d = sha1_pkg::ST_ROUND;
						end else begin
							state_d = sha1_pkg::ST_PAD;
						end
					end
				end
			end
			sha1_pkg::ST_ROUND: if (rnd_q == 7'd79) state_d = sha1_pkg::ST_FOLD;
			sha1_pkg::ST_FOLD: begin
				if (!fin_q) begin
					state_d = sha1_pkg::ST_IDLE;
				end else if (lenblk_q) begin
					state_d = sha1_pkg::ST_EMIT;
				end else begin
					state_d = sha1_pkg::ST_PAD;
				end
			end
			sha1_pkg::ST_PAD: if (fill_q == 6'd63) state_d = sha1_pkg::ST_ROUND;
			sha1_pkg::ST_EMIT: if (out_ready && idx_q == 3'd4) state_d = sha1_pkg::ST_IDLE;
			default: state_d = sha1_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha1_pkg::ST_IDLE;
			h_q[0]   <= sha1_pkg::H0_INIT;
			h_q[1]   <= sha1_pkg::H1_INIT;
			h_q[2]   <= sha1_pkg::H2_INIT;
			h_q[3]   <= sha1_pkg::H3_INIT;
			h_q[4]   <= sha1_pkg::H4_INIT;
			fill_q   <= '0;
			len_q    <= '0;
			rnd_q    <= '0;
			fin_q    <= 1'b0;
			lenblk_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sha1_pkg::ST_IDLE: begin
					if (take) begin
						fin_q <= q_req.end_of_message;
						if (q_req.byte_present) begin
							fill_q <= fill_q + 6'd1;
							len_q  <= len_q + 64'd8;
						end
						if (q_req.end_of_message) begin
							// pad byte goes right after the data byte if both come
							lenblk_q <= 1'b0;
							if (!(q_req.byte_present && fill_q == 6'd63)) begin
								fill_q   <= fill_q + 6'(q_req.byte_present) + 6'd1;
								lenblk_q <= (6'(fill_q + 6'(q_req.byte_present)) < 6'd56);
							end
						end
						rnd_q <= '0;
					end
				end
				sha1_pkg::ST_ROUND: rnd_q <= rnd_q + 7'd1;
				sha1_pkg::ST_FOLD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					rnd_q  <= '0;
					if (fin_q && !lenblk_q) begin
						// first pad block carried no length; next one is all zero+length
						lenblk_q <= 1'b1;
						// pad byte not yet placed if the data filled the block
						if (fill_q == 6'd0 && !pad_done_q) begin
							fill_q <= 6'd1;
						end
					end
				end
				sha1_pkg::ST_PAD: fill_q <= fill_q + 6'd1;
				sha1_pkg::ST_EMIT: begin
					if (out_ready) begin
						if (idx_q == 3'd4) begin
							idx_q    <= '0;
							h_q[0]   <= sha1_pkg::H0_INIT;
							h_q[1]   <= sha1_pkg::H1_INIT;
							h_q[2]   <= sha1_pkg::H2_INIT;
							h_q[3]   <= sha1_pkg::H3_INIT;
							h_q[4]   <= sha1_pkg::H4_INIT;
							len_q    <= '0;
							fill_q   <= '0;
							fin_q    <= 1'b0;
							lenblk_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_done_q <= 1'b0;
		end else if (take) begin
			pad_done_q <= q_req.end_of_message &&
				!(q_req.byte_present && fill_q == 6'd63);
		end else if (state_q == sha1_pkg::ST_FOLD && fin_q && !lenblk_q) begin
			pad_done_q <= 1'b1;
		end
	end

	// schedule window: bytes are written in place, big-endian; during rounds it recirculates
	logic [7:0] wr_byte;
	logic       wr_en;
	always_comb begin
		wr_en   = 1'b0;
		wr_byte = 8'h00;
		if (take && q_req.byte_present) begin
			wr_en   = 1'b1;
			wr_byte = q_req.data_byte;
		end else if (state_q == sha1_pkg::ST_PAD) begin
			wr_en   = 1'b1;
			wr_byte = pbyte;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sha1_pkg::ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wnext;
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end else begin
			if (wr_en) begin
				w_q[fill_q[5:2]][8'(31 - {fill_q[1:0], 3'd0}) -: 8] <= wr_byte;
			end
			// pad byte placed in the same request as the last data byte
			if (take && q_req.end_of_message && !(q_req.byte_present && fill_q == 6'd63))
			begin
				w_q[pad_pos[5:2]][8'(31 - {pad_pos[1:0], 3'd0}) -: 8] <= sha1_pkg::PAD_BYTE;
			end
			if (state_q == sha1_pkg::ST_FOLD && fin_q && !lenblk_q && !pad_done_q) begin
				w_q[0][31:24] <= sha1_pkg::PAD_BYTE;
			end
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end
	end

endmodule

// File: sv/sha1_stream_hasher.sv
// channel | dir | tdata (low bit up)       | tuser          | tlast
// s_axis  | in  | data_byte[7:0]           | byte_present   | end_of_message
// m_axis  | out | digest_word[31:0]        | word_index[2:0]| last_word
//
// Bytes enter a small request queue, one per cycle while it has room.
// After the 64th byte of a block the round engine is busy with 80 rounds and a fold.
// An end mark adds zero/length fill at one byte per cycle over one or two blocks,
// each followed by the rounds and fold, then five result words.
// Reset loads the initial chaining words and clears counts and queue; the byte store is not cleared.
// Stalls on m_axis hold the engine; s_axis keeps filling the queue.
module sha1_stream_hasher #(
	parameter int QueueDepth = sha1_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // byte_present
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // digest_word
	output logic [2:0]  m_axis_tuser,   // word_index
	output logic        m_axis_tlast
);

	sha1_pkg::req_t in_req, q_req;
	logic q_valid, q_ready;

	assign in_req.data_byte      = s_axis_tdata;
	assign in_req.byte_present   = s_axis_tuser;
	assign in_req.end_of_message = s_axis_tlast;

	sha1_front #(.Depth(QueueDepth)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req,
		.q_valid, .q_ready, .q_req
	);

	sha1_core u_core (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_req,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.digest_word(m_axis_tdata), .word_index(m_axis_tuser), .last_word(m_axis_tlast)
	);

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd4)))
		else $error("last flag mismatch");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser <= 3'd4))
		else $error("word index out of range");

	a_word_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
		else $error("digest words not contiguous");

endmodule

// File: tb/tb_sha1_stream_hasher.sv
`timescale 1ns / 100ps

module tb_sha1_stream_hasher;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} byte_req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_req_t;

	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // data_byte
	logic        s_axis_tuser;   // byte_present
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // digest_word
	logic [2:0]  m_axis_tuser;   // word_index
	logic        m_axis_tlast;

	sha1_stream_hasher dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predictor state
	logic [31:0] hash_h[5];
	logic [7:0]  msg_block[64];
	int unsigned msg_fill;
	logic [63:0] msg_bits;

	byte_req_t   pending_bytes[$];
	digest_req_t expected_digest[$];
	int          errors;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_sender;
	int          idle_cycles;
	int          digests_seen;
	int          bytes_sent;
	logic        in_acc_q;       // request taken at the last rising edge

	function automatic logic [31:0] rol(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	task automatic hash_clear();
		hash_h[0] = 32'h67452301;
		hash_h[1] = 32'hEFCDAB89;
		hash_h[2] = 32'h98BADCFE;
		hash_h[3] = 32'h10325476;
		hash_h[4] = 32'hC3D2E1F0;
		msg_fill = 0;
		msg_bits = '0;
	endtask

	task automatic hash_block();
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
		for (int r = 16; r < 80; r++)
			w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
		a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (r < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rol(a, 5) + f + e + k + w[r];
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
	endtask

	task automatic hash_step(input byte_req_t rq);
		digest_req_t dg;
		if (rq.byte_present) begin
			msg_block[msg_fill] = rq.data_byte;
			msg_fill++;
			msg_bits += 64'd8;
			if (msg_fill == 64) begin
				hash_block();
				msg_fill = 0;
			end
		end
		if (rq.end_of_message) begin
			msg_block[msg_fill] = 8'h80;
			msg_fill++;
			if (msg_fill > 56) begin
				while (msg_fill < 64) msg_block[msg_fill++] = 8'h00;
				hash_block();
				msg_fill = 0;
			end
			while (msg_fill < 56) msg_block[msg_fill++] = 8'h00;
			for (int i = 0; i < 8; i++)
				msg_block[63-i] = msg_bits[8*i +: 8];
			hash_block();
			for (int i = 0; i < 5; i++) begin
				dg.digest_word = hash_h[i];
				dg.word_index = 3'(i);
				dg.last_word = (i == 4);
				expected_digest.push_back(dg);
			end
			hash_clear();
		end
	endtask

	task automatic add_msg(input int len, input int gap_pct);
		byte_req_t rq;
		for (int i = 0; i < len; i++) begin
			// absent-byte items sprinkled in; the block just skips them
			if ($urandom_range(99) < gap_pct) begin
				rq = '{data_byte: 8'($urandom), byte_present: 1'b0, end_of_message: 1'b0};
				pending_bytes.push_back(rq);
			end
			rq = '{data_byte: 8'($urandom), byte_present: 1'b1,
				end_of_message: (i == len - 1) && $urandom_range(1)};
			pending_bytes.push_back(rq);
			if (rq.end_of_message) return;
		end
		rq = '{data_byte: 8'($urandom), byte_present: 1'b0, end_of_message: 1'b1};
		pending_bytes.push_back(rq);
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || expected_digest.size() != 0)
			@(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		in_acc_q <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				hash_step(pending_bytes.pop_front());
				bytes_sent++;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			// a request not yet taken keeps valid and data
			if (!s_axis_tvalid || in_acc_q) begin
				if (pending_bytes.size() != 0 && !hold_sender
						&& $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pending_bytes[0].data_byte;
					s_axis_tuser  <= pending_bytes[0].byte_present;
					s_axis_tlast  <= pending_bytes[0].end_of_message;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		digest_req_t exp_dg;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_digest.size() == 0) begin
					$display("%0t: unexpected digest word %h idx %0d last %b", $time,
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors++;
				end else begin
					exp_dg = expected_digest.pop_front();
					if (m_axis_tdata !== exp_dg.digest_word || m_axis_tuser !== exp_dg.word_index
							|| m_axis_tlast !== exp_dg.last_word) begin
						$display("%0t: mismatch expected %h/%0d/%b actual %h/%0d/%b", $time,
							exp_dg.digest_word, exp_dg.word_index, exp_dg.last_word,
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
						errors++;
					end
					if (exp_dg.last_word) digests_seen++;
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no traffic for %0d cycles", IDLE_LIMIT);
				$display("tb_sha1_stream_hasher: errors");
				$finish;
			end
		end
	end

	initial begin
		int len;
		int room;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		errors = 0;
		hold_sender = 0;
		idle_cycles = 0;
		digests_seen = 0;
		bytes_sent = 0;
		send_idle_pct = 13;
		recv_idle_pct = 56;
		hash_clear();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty message, "abc", extremes
		hold_sender = 1;
		pending_bytes.push_back('{data_byte: 8'hFF, byte_present: 1'b0, end_of_message: 1'b1});
		pending_bytes.push_back('{data_byte: 8'h61, byte_present: 1'b1, end_of_message: 1'b0});
		pending_bytes.push_back('{data_byte: 8'h62, byte_present: 1'b1, end_of_message: 1'b0});
		pending_bytes.push_back('{data_byte: 8'h63, byte_present: 1'b1, end_of_message: 1'b1});
		pending_bytes.push_back('{data_byte: 8'h00, byte_present: 1'b1, end_of_message: 1'b0});
		pending_bytes.push_back('{data_byte: 8'hAA, byte_present: 1'b0, end_of_message: 1'b0});
		pending_bytes.push_back('{data_byte: 8'hFF, byte_present: 1'b1, end_of_message: 1'b0});
		pending_bytes.push_back('{data_byte: 8'h55, byte_present: 1'b0, end_of_message: 1'b1});
		hold_sender = 0;
		wait_drained();

		// the sender holds off with a message queued until every digest word is back
		add_msg(60, 0);
		while (pending_bytes.size() != 0)
			@(posedge clk);
		hold_sender = 1;
		add_msg(5, 0);
		while (expected_digest.size() != 0)
			@(posedge clk);
		hold_sender = 0;
		wait_drained();

		// random messages around the one- and two-block padding edges
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 56; recv_idle_pct = 13;
			end else if (ph == 2) begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			while (bytes_sent + pending_bytes.size() < 110 * (ph + 1)) begin
				case ($urandom_range(3))
					0: len = $urandom_range(0, 8);
					1: len = $urandom_range(53, 66);
					2: len = $urandom_range(117, 130);
					default: len = $urandom_range(0, 40);
				endcase
				room = 110 * (ph + 1) - bytes_sent - pending_bytes.size();
				if (len > room) len = room;
				add_msg(len, 10);
			end
			wait_drained();
		end

		repeat (400) @(posedge clk);
		$display("covered %0d input requests and %0d digests, empty and pad-boundary lengths,",
			bytes_sent, digests_seen);
		$display("absent bytes, end marks with and without a byte, three idle mixes");
		if (errors == 0 && expected_digest.size() == 0)
			$display("tb_sha1_stream_hasher: clean");
		else
			$display("tb_sha1_stream_hasher: errors");
		$finish;
	end

endmodule
